>>> rtl/psrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psrl_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLEANUP_MS = 2'd2;

  localparam logic [31:0] WINDOW_MS_RESET  = 32'd60000;
  localparam logic [15:0] MAX_ATT_RESET    = 16'd5;
  localparam logic [31:0] CLEANUP_MS_RESET = 32'd30000;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] count;
    logic [63:0] start;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/per_source_connection_rate_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-source connection rate limiter, fixed window per key.
// Input stream s_*: one word per connection attempt, tdata = {now_ms, source_key}.
// Output stream m_*: one word per attempt, tdata = {sweep_done, table_full,
// attempt_count, limited}, zero padded to 24 bits.
// Config: cfg_we/cfg_index/cfg_data write window_ms (0), max_attempts (1) and
// cleanup_interval_ms (2); other indexes are dropped. Write only while idle.
// The entry table lives in one single-port-read RAM that is scanned one entry
// a cycle; a single 64-bit subtract/compare unit serves the window check, the
// cleanup check and the aging test of each entry.
// A key of 0 skips the table scan and goes straight to the cleanup check; any other
// key scans the whole table first, and a sweep adds a second pass over it.
// The block takes one attempt at a time; s_tready is high only in idle, so a new
// attempt is accepted only once the last result is in the output register.
// The result sits in an output register, so the next attempt is accepted while
// a result still waits; if the receiver stalls, the finished attempt after that
// holds until the register frees.
// Reset (rst, synchronous) restores config defaults, then runs a clearing pass
// over every RAM entry with s_tready low.
module per_source_connection_rate_limiter #(
  parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [psrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [psrl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [31:0] source_key, [95:32] now_ms
  input  wire logic [psrl_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] limited, [16:1] attempt_count, [17] table_full, [18] sweep_done
  output logic [psrl_pkg::OUT_DATA_W-1:0]       m_tdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [IW:0]   DEPTH    = (IW+1)'(TABLE_ENTRIES);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_SWCHK = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;

  // config
  logic [31:0] window_ms;
  logic [15:0] max_attempts;
  logic [31:0] cleanup_ms;

  // table RAM
  psrl_pkg::entry_t mem [TABLE_ENTRIES];
  psrl_pkg::entry_t rd_data;
  psrl_pkg::entry_t mem_wdata;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic             mem_re;

  // scan bookkeeping
  logic [IW:0]   issue_idx;
  logic          chk_pend;
  logic [IW-1:0] chk_idx;
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic [15:0]   hit_count;
  logic [63:0]   hit_start;
  logic          free_found;
  logic [IW-1:0] free_idx;

  // current item
  logic [31:0] key;
  logic [63:0] now;
  logic [63:0] last_sweep;
  logic        res_limited;
  logic [15:0] res_count;
  logic        res_full;
  logic        res_swept;

  // shared subtract / compare unit
  logic [63:0] sub_b;
  logic [63:0] thr;
  logic [63:0] diff;
  logic        diff_gt;
  logic        diff_eq;

  logic [15:0] inc_count;
  logic        issuing;
  logic        scan_last;

  always_comb begin
    unique case (state)
      S_UPD: begin
        sub_b = hit_start;
        thr   = {32'd0, window_ms};
      end
      S_SWCHK: begin
        sub_b = last_sweep;
        thr   = {32'd0, cleanup_ms};
      end
      default: begin
        sub_b = rd_data.start;
        thr   = {31'd0, window_ms, 1'b0};
      end
    endcase
    diff    = now - sub_b;
    diff_gt = diff > thr;
    diff_eq = diff == thr;
  end

  assign inc_count = (hit_count < psrl_pkg::COUNT_MAX) ? hit_count + 16'd1 : hit_count;
  assign issuing   = (issue_idx < DEPTH);
  assign scan_last = chk_pend && (chk_idx == LAST_IDX);
  assign s_tready  = (state == S_IDLE);

  // RAM write port and read enable
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = issue_idx[IW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        mem_re = issuing;
      end
      S_UPD: begin
        if (hit_found) begin
          mem_we          = 1'b1;
          mem_waddr       = hit_idx;
          mem_wdata.valid = 1'b1;
          mem_wdata.key   = key;
          mem_wdata.count = diff_gt ? 16'd1 : inc_count;
          mem_wdata.start = diff_gt ? now : hit_start;
        end else if (free_found) begin
          mem_we          = 1'b1;
          mem_waddr       = free_idx;
          mem_wdata.valid = 1'b1;
          mem_wdata.key   = key;
          mem_wdata.count = 16'd1;
          mem_wdata.start = now;
        end
      end
      S_SWEEP: begin
        mem_re = issuing;
        if (chk_pend && rd_data.valid && diff_gt) begin
          mem_we          = 1'b1;
          mem_waddr       = chk_idx;
          mem_wdata       = rd_data;
          mem_wdata.valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[issue_idx[IW-1:0]];
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms    <= psrl_pkg::WINDOW_MS_RESET;
      max_attempts <= psrl_pkg::MAX_ATT_RESET;
      cleanup_ms   <= psrl_pkg::CLEANUP_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psrl_pkg::CFG_WINDOW_MS:  window_ms    <= cfg_data;
        psrl_pkg::CFG_MAX_ATT:    max_attempts <= cfg_data[15:0];
        psrl_pkg::CFG_CLEANUP_MS: cleanup_ms   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      issue_idx  <= '0;
      chk_pend   <= 1'b0;
      m_tvalid   <= 1'b0;
      last_sweep <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      // S_DONE handles its own handoff of the output register
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          issue_idx <= issue_idx + 1'b1;
          if (issue_idx[IW-1:0] == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            key         <= s_tdata[31:0];
            now         <= s_tdata[95:32];
            issue_idx   <= '0;
            chk_pend    <= 1'b0;
            hit_found   <= 1'b0;
            free_found  <= 1'b0;
            res_limited <= 1'b0;
            res_count   <= 16'd0;
            res_full    <= 1'b0;
            res_swept   <= 1'b0;
            state       <= (s_tdata[31:0] == 32'd0) ? S_SWCHK : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
          end
          // issuing is already low on the last check, so chk_pend drops here
          chk_pend <= issuing;
          chk_idx  <= issue_idx[IW-1:0];
          if (chk_pend) begin
            if (rd_data.valid && rd_data.key == key && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_idx;
              hit_count <= rd_data.count;
              hit_start <= rd_data.start;
            end
            if (!rd_data.valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
          end
          if (scan_last) begin
            state     <= S_UPD;
            issue_idx <= '0;
          end
        end
        S_UPD: begin
          if (hit_found) begin
            if (diff_gt) begin
              res_count <= 16'd1;
            end else begin
              res_count   <= inc_count;
              res_limited <= inc_count > max_attempts;
            end
          end else begin
            res_count <= 16'd1;
            res_full  <= !free_found;
          end
          state <= S_SWCHK;
        end
        S_SWCHK: begin
          if (!res_limited && (diff_gt || diff_eq)) begin
            res_swept  <= 1'b1;
            last_sweep <= now;
            state      <= S_SWEEP;
          end else begin
            state <= S_DONE;
          end
        end
        S_SWEEP: begin
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
          end
          chk_pend <= issuing;
          chk_idx  <= issue_idx[IW-1:0];
          if (scan_last) begin
            state     <= S_DONE;
            issue_idx <= '0;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, res_swept, res_full, res_count, res_limited};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int ENTRIES     = psrl_pkg::TABLE_ENTRIES_DEF;
  localparam int POOL_SIZE   = 20;
  localparam int HOLD_CYCLES = 600;
  localparam int HAMMER_RUN  = 40;
  localparam longint unsigned CYCLE_LIMIT = 10_000_000;

  // index 3 is not decoded by the block; writes to it must be dropped
  localparam logic [psrl_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [31:0] HAMMER_KEY = 32'h7E57_0001;

  typedef struct packed {
    logic        sweep_done;
    logic        table_full;
    logic [15:0] attempt_count;
    logic        limited;
  } verdict_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] at_ms;
    logic        typed;
    verdict_t    want;
  } probe_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [psrl_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [psrl_pkg::CFG_DATA_W-1:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [psrl_pkg::IN_DATA_W-1:0] s_tdata;   // [31:0] source_key, [95:32] now_ms
  logic m_tvalid;
  logic m_tready;
  // [0] limited, [16:1] attempt_count, [17] table_full, [18] sweep_done
  logic [psrl_pkg::OUT_DATA_W-1:0] m_tdata;

  per_source_connection_rate_limiter #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // shadow of the block's table and registers
  logic [31:0] slot_key   [ENTRIES];
  logic [15:0] slot_count [ENTRIES];
  logic [63:0] slot_start [ENTRIES];
  logic        slot_used  [ENTRIES];
  logic [63:0] last_aging_ms;
  logic [31:0] win_ms;
  logic [15:0] max_att;
  logic [31:0] aging_gap_ms;

  verdict_t pending_verdicts[$];
  int fault_count = 0;
  longint unsigned cycle_count = 0;
  bit idle_en = 1'b1;
  bit hold_rx = 1'b0;
  logic [63:0] clock_ms = 64'd0;
  logic [31:0] key_pool [POOL_SIZE];

  // directed words; want is {sweep_done, table_full, attempt_count, limited}
  probe_t probes [27] = '{
    '{32'hA5A5_0001, 64'd100,   1'b1, '{1'b0, 1'b0, 16'd1, 1'b0}},
    '{32'hA5A5_0001, 64'd200,   1'b0, '0},
    '{32'hA5A5_0001, 64'd300,   1'b0, '0},
    '{32'hA5A5_0001, 64'd400,   1'b0, '0},
    '{32'hA5A5_0001, 64'd500,   1'b0, '0},
    '{32'hA5A5_0001, 64'd600,   1'b1, '{1'b0, 1'b0, 16'd6, 1'b1}},
    '{32'h0000_0000, 64'd700,   1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
    '{32'h0000_0000, 64'd40000, 1'b1, '{1'b1, 1'b0, 16'd0, 1'b0}},
    '{32'hA5A5_0001, 64'd60101, 1'b1, '{1'b0, 1'b0, 16'd1, 1'b0}},
    '{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFF, 64'd5,     1'b0, '0},   // time went backwards
    '{32'hA5A5_0001, 64'd10,    1'b0, '0},   // aged out, takes the lowest free slot
    '{32'h1111_1102, 64'd20,    1'b0, '0},
    '{32'h1111_1103, 64'd20,    1'b0, '0},
    '{32'h1111_1104, 64'd20,    1'b0, '0},
    '{32'h1111_1105, 64'd20,    1'b0, '0},
    '{32'h1111_1106, 64'd20,    1'b0, '0},
    '{32'h1111_1107, 64'd20,    1'b0, '0},
    '{32'h1111_1108, 64'd20,    1'b0, '0},
    '{32'h1111_1109, 64'd20,    1'b0, '0},
    '{32'h1111_110A, 64'd20,    1'b0, '0},
    '{32'h1111_110B, 64'd20,    1'b0, '0},
    '{32'h1111_110C, 64'd20,    1'b0, '0},
    '{32'h1111_110D, 64'd20,    1'b0, '0},
    '{32'h1111_110E, 64'd20,    1'b0, '0},
    '{32'h1111_110F, 64'd20,    1'b0, '0},
    '{32'h5A5A_5A5A, 64'd30,    1'b1, '{1'b0, 1'b1, 16'd1, 1'b0}}   // no free slot
  };

  function automatic verdict_t judge_attempt(input logic [31:0] key, input logic [63:0] at_ms);
    verdict_t v;
    int hit;
    int slot;
    logic [63:0] aging_limit;
    v = '0;
    hit = -1;
    slot = -1;
    if (key != 32'd0) begin
      for (int i = 0; i < ENTRIES; i++)
        if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
      if (hit < 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !slot_used[i]) slot = i;
        if (slot >= 0) begin
          slot_used[slot]  = 1'b1;
          slot_key[slot]   = key;
          slot_count[slot] = 16'd1;
          slot_start[slot] = at_ms;
        end else begin
          v.table_full = 1'b1;
        end
        v.attempt_count = 16'd1;
      end else if (at_ms - slot_start[hit] > {32'd0, win_ms}) begin
        slot_count[hit] = 16'd1;
        slot_start[hit] = at_ms;
        v.attempt_count = 16'd1;
      end else begin
        if (slot_count[hit] != 16'hFFFF) slot_count[hit] = slot_count[hit] + 16'd1;
        v.attempt_count = slot_count[hit];
        v.limited = (slot_count[hit] > max_att);
      end
    end
    if (!v.limited && (at_ms - last_aging_ms) >= {32'd0, aging_gap_ms}) begin
      last_aging_ms = at_ms;
      aging_limit = {31'd0, win_ms, 1'b0};
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && at_ms - slot_start[i] > aging_limit) slot_used[i] = 1'b0;
      v.sweep_done = 1'b1;
    end
    return v;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [63:0] time_step();
    logic [63:0] w;
    int unsigned r;
    w = (win_ms == 32'd0) ? 64'd1 : {32'd0, win_ms};
    r = $urandom_range(0, 99);
    if (r < 45) return (w * $urandom_range(0, 63)) >> 8;
    if (r < 75) return (w * $urandom_range(0, 255)) >> 8;
    if (r < 90) return w - 64'd1 + $urandom_range(0, 2);   // around the window edge
    return 2 * w + $urandom_range(0, 2);                   // around the aging edge
  endfunction

  task automatic write_reg(input logic [psrl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      psrl_pkg::CFG_WINDOW_MS:  win_ms = data;
      psrl_pkg::CFG_MAX_ATT:    max_att = data[15:0];
      psrl_pkg::CFG_CLEANUP_MS: aging_gap_ms = data;
      default: ;
    endcase
  endtask

  task automatic send_attempt(input logic [31:0] key, input logic [63:0] at_ms,
                              input logic typed, input verdict_t want);
    int gap;
    verdict_t predicted;
    verdict_t queued;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {at_ms, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = judge_attempt(key, at_ms);
    queued = typed ? want : predicted;
    pending_verdicts = {pending_verdicts, queued};
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input bit reconfig, input logic [31:0] win, input logic [31:0] att,
                           input logic [31:0] gap_ms, input int n, input bit quiet,
                           input bit squeeze);
    int unsigned r;
    logic [31:0] key;
    drain();
    if (reconfig) begin
      write_reg(psrl_pkg::CFG_WINDOW_MS, win);
      write_reg(psrl_pkg::CFG_MAX_ATT, att);
      write_reg(psrl_pkg::CFG_CLEANUP_MS, gap_ms);
      write_reg(CFG_UNUSED, $urandom);
    end
    foreach (key_pool[i]) begin
      do key_pool[i] = $urandom; while (key_pool[i] == 32'd0);
    end
    idle_en = !quiet;
    if (squeeze) hold_rx = 1'b1;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) clock_ms = {$urandom, $urandom};
      else if (r < 6) clock_ms = clock_ms - $urandom_range(1, 500);
      else clock_ms = clock_ms + time_step();
      r = $urandom_range(0, 99);
      if (r < 6) key = 32'd0;
      else if (r < 12) key = $urandom;
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_attempt(key, clock_ms, 1'b0, '0);
    end
    idle_en = 1'b1;
  endtask

  // one key hammered back to back at a fixed time, well past its limit
  task automatic hammer_key();
    drain();
    write_reg(psrl_pkg::CFG_WINDOW_MS, 32'd1);
    write_reg(psrl_pkg::CFG_CLEANUP_MS, 32'd0);
    clock_ms = clock_ms + 64'h100_0000_0000;
    send_attempt(32'd0, clock_ms, 1'b0, '0);   // sweep empties the table
    drain();
    write_reg(psrl_pkg::CFG_WINDOW_MS, 32'hFFFF_FFFF);
    write_reg(psrl_pkg::CFG_MAX_ATT, 32'd8);
    write_reg(psrl_pkg::CFG_CLEANUP_MS, 32'hFFFF_FFFF);
    idle_en = 1'b0;
    repeat (HAMMER_RUN) send_attempt(HAMMER_KEY, clock_ms, 1'b0, '0);
    idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("per_source_connection_rate_limiter test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result word with no attempt pending: %h", m_tdata);
        fault_count++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (m_tdata[0] !== exp_v.limited) begin
          $error("limited: expected %0d, got %0d", exp_v.limited, m_tdata[0]);
          fault_count++;
        end
        if (m_tdata[16:1] !== exp_v.attempt_count) begin
          $error("attempt_count: expected %0d, got %0d", exp_v.attempt_count, m_tdata[16:1]);
          fault_count++;
        end
        if (m_tdata[17] !== exp_v.table_full) begin
          $error("table_full: expected %0d, got %0d", exp_v.table_full, m_tdata[17]);
          fault_count++;
        end
        if (m_tdata[18] !== exp_v.sweep_done) begin
          $error("sweep_done: expected %0d, got %0d", exp_v.sweep_done, m_tdata[18]);
          fault_count++;
        end
      end
    end
  end

  // receiver: random ready runs, plus one long hold-off on request
  initial begin
    int run;
    run = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_rx = 1'b0;
        run = 0;
      end else if (!idle_en) begin
        m_tready <= 1'b1;
      end else if (run > 0) begin
        run--;
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
        run = pick_gap();
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    foreach (slot_used[i]) begin
      slot_used[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_count[i] = '0;
      slot_start[i] = '0;
    end
    last_aging_ms = '0;
    win_ms        = psrl_pkg::WINDOW_MS_RESET;
    max_att       = psrl_pkg::MAX_ATT_RESET;
    aging_gap_ms  = psrl_pkg::CLEANUP_MS_RESET;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // table clearing pass after reset
    do @(posedge clk); while (!s_tready);

    foreach (probes[i])
      send_attempt(probes[i].key, probes[i].at_ms, probes[i].typed, probes[i].want);
    clock_ms = 64'd100;

    run_phase(1'b0, 32'd0, 32'd0, 32'd0, 110, 1'b0, 1'b0);
    run_phase(1'b1, 32'd1, 32'd1, 32'd1, 110, 1'b0, 1'b0);
    run_phase(1'b1, 32'd0, 32'd0, 32'd0, 110, 1'b0, 1'b0);
    run_phase(1'b1, 32'd100, 32'd3, 32'd50, 110, 1'b0, 1'b1);
    run_phase(1'b1, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 110, 1'b1, 1'b0);
    // upper bits of the max_attempts write must be dropped
    run_phase(1'b1, 32'd1000, {16'($urandom_range(1, 16'hFFFF)), 16'd4}, 32'd0, 110,
              1'b1, 1'b0);
    run_phase(1'b1, $urandom_range(1, 5000), $urandom_range(1, 8),
              $urandom_range(0, 15000), 110, 1'b0, 1'b0);
    run_phase(1'b1, 32'd20, {16'hFFFF, 16'd2}, 32'd10, 110, 1'b0, 1'b0);
    hammer_key();
    run_phase(1'b1, psrl_pkg::WINDOW_MS_RESET, {16'd0, psrl_pkg::MAX_ATT_RESET},
              psrl_pkg::CLEANUP_MS_RESET, 110, 1'b0, 1'b0);

    drain();
    repeat (2 * ENTRIES + 6) @(posedge clk);
    if (fault_count == 0)
      $display("per_source_connection_rate_limiter test passed");
    else
      $display("per_source_connection_rate_limiter test failed");
    $finish;
  end

endmodule

>>> files.f
rtl/psrl_pkg.sv
rtl/per_source_connection_rate_limiter.sv
verif/testbench.sv
